[hdl/engine_actuator_sequencer_assert.svh]
// assertion macros used by the sequencer top file
`ifndef ENGINE_ACTUATOR_SEQUENCER_ASSERT_SVH
`define ENGINE_ACTUATOR_SEQUENCER_ASSERT_SVH

// property checked outside reset
`define EAS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define EAS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/eas_pkg.sv]
package eas_pkg;

    // register indexes on the config port
    localparam int unsigned CfgIndexWidth = 3;
    localparam logic [CfgIndexWidth-1:0] REG_PRIME_TIME          = 3'd0;
    localparam logic [CfgIndexWidth-1:0] REG_FAN_ON_TEMP         = 3'd1;
    localparam logic [CfgIndexWidth-1:0] REG_FAN_HYSTERESIS      = 3'd2;
    localparam logic [CfgIndexWidth-1:0] REG_SOLENOID_ON_SPEED   = 3'd3;
    localparam logic [CfgIndexWidth-1:0] REG_SOLENOID_HYSTERESIS = 3'd4;

    localparam int unsigned CfgDataWidth = 16;

    // reset values of the registers
    localparam logic [15:0]        PRIME_TIME_RST          = 16'd2000;
    localparam logic signed [15:0] FAN_ON_TEMP_RST         = 16'sd95;
    localparam logic [14:0]        FAN_HYSTERESIS_RST      = 15'd5;
    localparam logic [14:0]        SOLENOID_ON_SPEED_RST   = 15'd4000;
    localparam logic [14:0]        SOLENOID_HYSTERESIS_RST = 15'd200;

    // prime time accumulator
    localparam int unsigned ElapsedWidth = 17;
    localparam logic [ElapsedWidth-1:0] ELAPSED_MAX = '1;

    // compare width for the hysteresis units
    localparam int unsigned CmpWidth = 17;

    typedef struct packed {
        logic [15:0]        tick_time;
        logic               ignition_on;
        logic               engine_running;
        logic               engine_cranking;
        logic signed [15:0] coolant_temp;
        logic [14:0]        engine_speed;
    } t_in_word;

    typedef struct packed {
        logic relay_drive;
        logic pump_drive;
        logic fan_drive;
        logic solenoid_drive;
    } t_out_word;

    typedef struct packed {
        logic [15:0]        prime_time;
        logic signed [15:0] fan_on_temp;
        logic [14:0]        fan_hysteresis;
        logic [14:0]        solenoid_on_speed;
        logic [14:0]        solenoid_hysteresis;
    } t_cfg;

    // per-tick control handed to the prime unit
    typedef struct packed {
        logic advance;
        logic ignition_on;
        logic engine_running;
        logic engine_cranking;
    } t_tick_ctrl;

endpackage

[hdl/eas_cfg.sv]
module eas_cfg (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [eas_pkg::CfgIndexWidth-1:0]    i_cfg_index,
    input  logic [eas_pkg::CfgDataWidth-1:0]     i_cfg_data,
    output eas_pkg::t_cfg                        o_cfg
);

    eas_pkg::t_cfg r_cfg;
    eas_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                eas_pkg::REG_PRIME_TIME:          n_cfg.prime_time = i_cfg_data;
                eas_pkg::REG_FAN_ON_TEMP:         n_cfg.fan_on_temp = signed'(i_cfg_data);
                eas_pkg::REG_FAN_HYSTERESIS:      n_cfg.fan_hysteresis = i_cfg_data[14:0];
                eas_pkg::REG_SOLENOID_ON_SPEED:   n_cfg.solenoid_on_speed = i_cfg_data[14:0];
                eas_pkg::REG_SOLENOID_HYSTERESIS: n_cfg.solenoid_hysteresis = i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prime_time          <= eas_pkg::PRIME_TIME_RST;
            r_cfg.fan_on_temp         <= eas_pkg::FAN_ON_TEMP_RST;
            r_cfg.fan_hysteresis      <= eas_pkg::FAN_HYSTERESIS_RST;
            r_cfg.solenoid_on_speed   <= eas_pkg::SOLENOID_ON_SPEED_RST;
            r_cfg.solenoid_hysteresis <= eas_pkg::SOLENOID_HYSTERESIS_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hdl/eas_prime.sv]
module eas_prime (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  eas_pkg::t_tick_ctrl i_ctrl,
    input  logic [15:0]         i_tick_time,
    input  logic [15:0]         i_prime_time,
    output logic                o_pump_drive
);

    logic                              r_pending;
    logic                              n_pending;
    logic [eas_pkg::ElapsedWidth-1:0]  r_elapsed;
    logic [eas_pkg::ElapsedWidth-1:0]  n_elapsed;
    logic [eas_pkg::ElapsedWidth:0]    sum;
    logic                              prime_done;

    assign sum = {1'b0, r_elapsed} + {{(eas_pkg::ElapsedWidth - 15){1'b0}}, i_tick_time};
    // elapsed is checked before this tick is added
    assign prime_done = (i_tick_time >= i_prime_time)
                     || (r_elapsed >= {{(eas_pkg::ElapsedWidth - 16){1'b0}}, i_prime_time});

    always_comb begin
        n_pending    = r_pending;
        n_elapsed    = r_elapsed;
        o_pump_drive = 1'b0;
        priority if (i_ctrl.engine_running || i_ctrl.engine_cranking) begin
            o_pump_drive = 1'b1;
        end else if (i_ctrl.ignition_on && r_pending) begin
            if (prime_done) begin
                n_pending = 1'b0;
            end else begin
                o_pump_drive = 1'b1;
                n_elapsed = sum[eas_pkg::ElapsedWidth] ? eas_pkg::ELAPSED_MAX
                                                       : sum[eas_pkg::ElapsedWidth-1:0];
            end
        end else begin
            o_pump_drive = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b1;
            r_elapsed <= '0;
        end else if (i_ctrl.advance) begin
            r_pending <= n_pending;
            r_elapsed <= n_elapsed;
        end
    end

endmodule

[hdl/eas_hyst.sv]
module eas_hyst (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_advance,
    input  logic                                i_active,
    input  logic signed [eas_pkg::CmpWidth-1:0] i_value,
    input  logic [14:0]                         i_hysteresis,
    input  logic signed [eas_pkg::CmpWidth-1:0] i_threshold,
    output logic                                o_latched
);

    logic                                r_latched;
    logic                                n_latched;
    logic signed [eas_pkg::CmpWidth-1:0] low_sum;

    // value plus hysteresis always fits the compare width
    assign low_sum = i_value
                   + signed'({{(eas_pkg::CmpWidth - 15){1'b0}}, i_hysteresis});

    always_comb begin
        priority if (!i_active) begin
            n_latched = 1'b0;
        end else if (r_latched) begin
            n_latched = !(low_sum < i_threshold);
        end else begin
            n_latched = (i_value >= i_threshold);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latched <= 1'b0;
        end else if (i_advance) begin
            r_latched <= n_latched;
        end
    end

    assign o_latched = n_latched;

endmodule

[hdl/engine_actuator_sequencer.sv]
// channel | direction | handshake                  | word
// in      | into      | i_in_valid / o_in_stall    | i_in_word  (eas_pkg::t_in_word)
// out     | out of    | o_out_valid / i_out_stall  | o_out_word (eas_pkg::t_out_word)
// cfg     | into      | i_cfg_wr_en, no stall      | i_cfg_index, i_cfg_data
//
// a word passes the input then the result register; one word per cycle while i_out_stall is low
// the rate is set by the single state update per tick, done in the cycle a word leaves
// the input register for the result register
// reset is synchronous, active low; it restores register defaults and restarts the prime
// a stalled result holds; the input register keeps filling, so stall reaches the input
// only when both registers are full
`include "engine_actuator_sequencer_assert.svh"

module engine_actuator_sequencer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  eas_pkg::t_in_word                 i_in_word,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output eas_pkg::t_out_word                o_out_word,
    input  logic                              i_cfg_wr_en,
    input  logic [eas_pkg::CfgIndexWidth-1:0] i_cfg_index,
    input  logic [eas_pkg::CfgDataWidth-1:0]  i_cfg_data
);

    eas_pkg::t_cfg       cfg;
    eas_pkg::t_in_word   r_in;
    logic                r_in_valid;
    logic                n_in_valid;
    eas_pkg::t_out_word  r_out;
    eas_pkg::t_out_word  n_out;
    logic                r_out_valid;
    logic                n_out_valid;
    logic                in_accept;
    logic                advance;
    logic                active;
    eas_pkg::t_tick_ctrl tick_ctrl;
    logic                pump;
    logic                fan;
    logic                solenoid;

    // a word moves into the result register when that register is free or draining
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    // fan and solenoid only run with the engine running and not cranking
    assign active = r_in.engine_running && !r_in.engine_cranking;

    assign tick_ctrl.advance         = advance;
    assign tick_ctrl.ignition_on     = r_in.ignition_on;
    assign tick_ctrl.engine_running  = r_in.engine_running;
    assign tick_ctrl.engine_cranking = r_in.engine_cranking;

    eas_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    eas_prime u_prime (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (tick_ctrl),
        .i_tick_time  (r_in.tick_time),
        .i_prime_time (cfg.prime_time),
        .o_pump_drive (pump)
    );

    // coolant temperature is signed, sign extend to the compare width
    eas_hyst u_fan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_active     (active),
        .i_value      (eas_pkg::CmpWidth'(r_in.coolant_temp)),
        .i_hysteresis (cfg.fan_hysteresis),
        .i_threshold  (eas_pkg::CmpWidth'(cfg.fan_on_temp)),
        .o_latched    (fan)
    );

    // speed is unsigned, zero extend to the compare width
    eas_hyst u_solenoid (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_active     (active),
        .i_value      (signed'({{(eas_pkg::CmpWidth - 15){1'b0}}, r_in.engine_speed})),
        .i_hysteresis (cfg.solenoid_hysteresis),
        .i_threshold  (signed'({{(eas_pkg::CmpWidth - 15){1'b0}}, cfg.solenoid_on_speed})),
        .o_latched    (solenoid)
    );

    always_comb begin
        n_out.relay_drive    = r_in.ignition_on;
        n_out.pump_drive     = pump;
        n_out.fan_drive      = fan;
        n_out.solenoid_drive = solenoid;
    end

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_accept) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_word;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    `EAS_ASSERT(a_relay_follows_ign, i_clk, i_rst_n,
        advance |=> (r_out.relay_drive == $past(r_in.ignition_on)),
        "relay drive does not follow ignition")
    `EAS_ASSERT(a_pump_when_running, i_clk, i_rst_n,
        advance && (r_in.engine_running || r_in.engine_cranking) |=> r_out.pump_drive,
        "pump off while engine runs or cranks")
    `EAS_ASSERT(a_forced_off_idle, i_clk, i_rst_n,
        advance && !active |=> (!r_out.fan_drive && !r_out.solenoid_drive),
        "fan or solenoid on while engine not running")
    `EAS_ASSERT(a_no_overwrite, i_clk, i_rst_n,
        r_out_valid && i_out_stall |-> !advance,
        "result overwritten while stalled")
    `EAS_ASSERT_ALWAYS(a_reset_empty, i_clk,
        !i_rst_n |=> (!r_in_valid && !r_out_valid),
        "pipeline not empty after reset")

endmodule
